[src/plt_pkg.sv]
// shared types, constants and codes of the ping latency tracker
// no dependencies; imported by every module under src
package plt_pkg;

  localparam int SAMPLE_DEPTH   = 60;
  localparam int AVERAGE_WINDOW = 600;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int RTT_W    = 16;
  localparam int SAMPLE_W = 17;
  localparam int CNT_W    = 10;
  localparam int DEPTH_W  = $clog2(SAMPLE_DEPTH);
  localparam int NUM_W    = RTT_W + CNT_W;
  localparam int STEP_W   = $clog2(NUM_W);
  localparam int CMP_W    = RTT_W + 5;

  localparam int MIN_AVG_COUNT = 10;
  localparam int RATIO_DEN     = 10;
  localparam int RESTART_NUM   = 7;
  localparam int ACCEPT_NUM    = 13;

  localparam logic signed [SAMPLE_W-1:0] EMPTY_SAMPLE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PING_RESULT = 2'd0,
    OP_PING_SENT   = 2'd1,
    OP_READ        = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIST,
    ST_RESTART,
    ST_TEST,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              wr;
    logic              shift;
    logic              rd;
    logic [SLOT_W-1:0] slot;
    logic [RTT_W-1:0]  data;
  } hist_cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

endpackage

[src/plt_hist.sv]
// sample history: circular buffer memory with per-entry valid bits
// depends on plt_pkg
module plt_hist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  plt_pkg::hist_cmd_t                    cmd,
  output logic signed [plt_pkg::SAMPLE_W-1:0]   sample
);
  import plt_pkg::*;

  localparam logic [DEPTH_W:0]   DEPTH_L = (DEPTH_W + 1)'(SAMPLE_DEPTH);
  localparam logic [DEPTH_W-1:0] TOP_L   = DEPTH_W'(SAMPLE_DEPTH - 1);

  logic [RTT_W-1:0]        mem [SAMPLE_DEPTH];
  logic [SAMPLE_DEPTH-1:0] valid_r;
  logic [DEPTH_W-1:0]      base_r;
  logic [DEPTH_W-1:0]      base_nxt;
  logic                    in_range;
  logic [DEPTH_W-1:0]      slot_eff;
  logic [DEPTH_W:0]        sum;
  logic [DEPTH_W-1:0]      phys;
  logic [RTT_W-1:0]        rd_data_r;
  logic                    rd_vld_r;

  // logical slot i lives at physical entry (base + i) mod depth
  assign in_range = (7'(cmd.slot) < 7'(SAMPLE_DEPTH));
  assign slot_eff = in_range ? cmd.slot[DEPTH_W-1:0] : '0;
  assign sum      = {1'b0, base_r} + {1'b0, slot_eff};
  assign phys     = (sum >= DEPTH_L) ? DEPTH_W'(sum - DEPTH_L) : sum[DEPTH_W-1:0];
  assign base_nxt = (base_r == '0) ? TOP_L : base_r - DEPTH_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      base_r  <= '0;
    end else if (cmd.shift) begin
      // the dropped top entry becomes the new empty slot 0
      base_r            <= base_nxt;
      valid_r[base_nxt] <= 1'b0;
    end else if (cmd.wr && in_range) begin
      valid_r[phys] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && in_range && !cmd.shift) begin
      mem[phys] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[phys];
      rd_vld_r  <= valid_r[phys] && in_range;
    end
  end

  assign sample = rd_vld_r ? $signed({1'b0, rd_data_r}) : EMPTY_SAMPLE;

endmodule

[src/plt_div.sv]
// restoring divider, one quotient bit per cycle
// depends on plt_pkg
module plt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  plt_pkg::div_req_t           req,
  output logic                        done,
  output logic [plt_pkg::NUM_W-1:0]   quot
);
  import plt_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? CNT_W'(trial - {1'b0, den_r}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

[src/ping_latency_tracker.sv]
// ping latency tracker: sample history, latest time and running average
// path from accept to out_tvalid: read, ping-sent and out-of-range beats pass HIST, READ and OUT;
//   a rejected outlier adds RESTART and TEST, and an update adds MUL and the divider's 26-bit quotient
// a new beat is taken only after the last result loads into the output register, so out_tready stalls it
// reset: synchronous active-low rst_n empties all history slots, zeroes latest time,
//   average and count; depends on plt_pkg, plt_hist, plt_div
module ping_latency_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[1:0], slot_index[7:2], rtt_ms[23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // sample_value[16:0], last_rtt[32:17],
                                  // avg_rtt[48:33], avg_samples[58:49], zero[63:59]
);
  import plt_pkg::*;

  localparam logic [CNT_W-1:0] WIN_L     = CNT_W'(AVERAGE_WINDOW);
  localparam logic [CNT_W-1:0] WIN_M1_L  = CNT_W'(AVERAGE_WINDOW - 1);
  localparam logic [CNT_W-1:0] MIN_CNT_L = CNT_W'(MIN_AVG_COUNT);

  state_t state_r;
  state_t state_nxt;

  // captured beat
  op_t               op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [RTT_W-1:0]  rtt_r;

  // tracker state
  logic [RTT_W-1:0] latest_r;
  logic [RTT_W-1:0] avg_r;
  logic [CNT_W-1:0] cnt_r;

  // average update datapath
  logic [NUM_W-1:0] prod_r;
  logic [CNT_W-1:0] den_r;
  logic             at_win;
  logic [CNT_W-1:0] mult;
  logic             rec_ok;
  logic             restart;
  logic             accept_upd;
  logic [CMP_W-1:0] rtt_x10;

  hist_cmd_t                   hist_cmd;
  logic signed [SAMPLE_W-1:0]  sample;
  div_req_t                    div_req;
  logic                        div_done;
  logic [NUM_W-1:0]            div_quot;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] o_sample_r;
  logic [RTT_W-1:0]           o_latest_r;
  logic [RTT_W-1:0]           o_avg_r;
  logic [CNT_W-1:0]           o_cnt_r;
  logic                       out_load;

  plt_hist u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (hist_cmd),
    .sample (sample)
  );

  plt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // a ping result only counts when its slot exists
  assign rec_ok = (op_r == OP_PING_RESULT) && (7'(slot_r) < 7'(SAMPLE_DEPTH));

  // t < floor(7a/10)  <=>  10(t+1) <= 7a
  assign rtt_x10    = CMP_W'(rtt_r) * CMP_W'(RATIO_DEN);
  assign restart    = (rtt_x10 + CMP_W'(RATIO_DEN)) <= CMP_W'(avg_r) * CMP_W'(RESTART_NUM);
  // t <= floor(13a/10)  <=>  10t <= 13a
  assign accept_upd = (rtt_x10 <= CMP_W'(avg_r) * CMP_W'(ACCEPT_NUM))
                      || (cnt_r < MIN_CNT_L);

  assign at_win = (cnt_r == WIN_L);
  assign mult   = at_win ? WIN_M1_L : cnt_r;

  assign out_load = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_HIST;
      end
      ST_HIST: begin
        state_nxt = rec_ok ? ST_RESTART : ST_READ;
      end
      ST_RESTART:   state_nxt = ST_TEST;
      ST_TEST: begin
        state_nxt = accept_upd ? ST_MUL : ST_READ;
      end
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_READ;
      end
      ST_READ:      state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready      = 1'b0;
    hist_cmd.wr    = 1'b0;
    hist_cmd.shift = 1'b0;
    hist_cmd.rd    = 1'b0;
    hist_cmd.slot  = slot_r;
    hist_cmd.data  = rtt_r;
    div_req.start  = 1'b0;
    div_req.num    = prod_r + NUM_W'(rtt_r);
    div_req.den    = den_r;
    case (state_r)
      ST_IDLE:      in_tready      = 1'b1;
      ST_HIST: begin
        hist_cmd.wr    = rec_ok;
        hist_cmd.shift = (op_r == OP_PING_SENT);
      end
      ST_DIV_START: div_req.start  = 1'b1;
      ST_READ:      hist_cmd.rd    = 1'b1;
      default:      in_tready      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= op_t'(in_tdata[1:0]);
      slot_r <= in_tdata[7:2];
      rtt_r  <= in_tdata[23:8];
    end
  end

  // tracker state updates, one step per sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r <= '0;
      avg_r    <= '0;
      cnt_r    <= '0;
    end else begin
      case (state_r)
        ST_HIST: begin
          if (rec_ok) latest_r <= rtt_r;
        end
        ST_RESTART: begin
          if (restart) begin
            avg_r <= rtt_r;
            cnt_r <= CNT_W'(1);
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            avg_r <= div_quot[RTT_W-1:0];
            if (!at_win) cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        default: begin
          avg_r <= avg_r;
        end
      endcase
    end
  end

  // weighted numerator and divisor: window weighting or cumulative mean
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= NUM_W'(avg_r) * NUM_W'(mult);
      den_r  <= at_win ? WIN_L : cnt_r + CNT_W'(1);
    end
  end

  // output register parts the result from the next accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_load) begin
      o_sample_r <= sample;
      o_latest_r <= latest_r;
      o_avg_r    <= avg_r;
      o_cnt_r    <= cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, o_cnt_r, o_avg_r, o_latest_r, o_sample_r};

  // a beat is never followed by another in the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("beat accepted while previous one in flight");

  // divider completes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT))
    else $error("divider done outside wait state");

  // count never passes the window
  a_cnt_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[58:49] <= WIN_L))
    else $error("average count above window");

  // a negative sample is always the empty marker
  a_sample_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[SAMPLE_W-1]) |-> (&out_tdata[SAMPLE_W-1:0]))
    else $error("negative sample other than empty marker");

endmodule
